// File: rtl/core/spc_pkg.sv
package spc_pkg;

   localparam int POSITION_BITS_DEFAULT = 32;
   localparam int CMD_DEPTH = 4;
   localparam int RSP_DEPTH = 4;

   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 32;

   // Request operation codes
   localparam logic [2:0] OP_TICK       = 3'd0;
   localparam logic [2:0] OP_SET_TARGET = 3'd1;
   localparam logic [2:0] OP_ADD_TARGET = 3'd2;
   localparam logic [2:0] OP_ZERO       = 3'd3;
   localparam logic [2:0] OP_ADJUST     = 3'd4;

   // Axis modes
   localparam logic [1:0] AXIS_UNLIMITED = 2'd0;
   localparam logic [1:0] AXIS_MODULO    = 2'd1;
   localparam logic [1:0] AXIS_LIMITED   = 2'd2;

   // Register indexes
   localparam logic [CSR_INDEX_BITS-1:0] REG_AXIS_MODE       = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_MODULO_STEPS    = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] REG_LOWER_LIMIT     = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] REG_UPPER_LIMIT     = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] REG_BACKLASH_STEPS  = 3'd4;
   localparam logic [CSR_INDEX_BITS-1:0] REG_STEP_DELAY      = 3'd5;
   localparam logic [CSR_INDEX_BITS-1:0] REG_POWERSAVE_DELAY = 3'd6;
   localparam logic [CSR_INDEX_BITS-1:0] REG_REVERSE_DIR     = 3'd7;

   // Register reset values
   localparam logic signed [31:0] LOWER_LIMIT_RESET     = 32'sh8000_0001;
   localparam logic signed [31:0] UPPER_LIMIT_RESET     = 32'sh7fff_ffff;
   localparam logic [15:0]        STEP_DELAY_RESET      = 16'd1250;
   localparam logic [31:0]        POWERSAVE_DELAY_RESET = 32'd1000000;

   localparam logic [32:0] TICK_MAX = '1;

   typedef struct packed {
      logic [2:0]         operation;
      logic signed [31:0] value;
   } req_type;

   typedef struct packed {
      logic [3:0]         coil_pattern;
      logic signed [31:0] position;
      logic signed [31:0] target;
      logic               in_target;
   } rsp_type;

   typedef struct packed {
      logic [1:0]         axis_mode;
      logic [15:0]        modulo_steps;
      logic signed [31:0] lower_limit;
      logic signed [31:0] upper_limit;
      logic [11:0]        backlash_steps;
      logic [15:0]        step_delay;
      logic [31:0]        powersave_delay;
      logic               reverse_dir;
   } cfg_type;

   typedef enum logic [2:0] {
      CMD_NOP,
      CMD_TICK,
      CMD_SET_TARGET,
      CMD_ADD_TARGET,
      CMD_ZERO,
      CMD_ADJUST
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type       kind;
      logic signed [31:0] value;
   } cmd_type;

   // Half-step coil sequence
   function automatic logic [3:0] coil_of(input logic [2:0] phase);
      logic [3:0] pattern;
      case (phase)
         3'd0: pattern = 4'h3;
         3'd1: pattern = 4'h2;
         3'd2: pattern = 4'h6;
         3'd3: pattern = 4'h4;
         3'd4: pattern = 4'hC;
         3'd5: pattern = 4'h8;
         3'd6: pattern = 4'h9;
         default: pattern = 4'h1;
      endcase
      return pattern;
   endfunction

endpackage

// File: rtl/core/spc_fifo.sv
module spc_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wr_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] rd_data,
   output logic             empty
);

   // DEPTH is a power of two; pointers wrap naturally
   localparam int PTR_BITS   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int COUNT_BITS = $clog2(DEPTH + 1);

   logic [WIDTH-1:0]      mem_ff [DEPTH];
   logic [PTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [COUNT_BITS-1:0] count_ff, count_in;
   logic                  do_push, do_pop;

   assign full    = (count_ff == COUNT_BITS'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rd_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + PTR_BITS'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + PTR_BITS'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + COUNT_BITS'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - COUNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

// File: rtl/core/spc_front.sv
module spc_front import spc_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  req_type req_payload,
   output logic    full,
   output cmd_type cmd,
   output logic    cmd_valid,
   input  logic    cmd_pop
);

   cmd_type                cmd_in;
   logic [$bits(cmd_type)-1:0] cmd_bits;
   logic                   cmd_empty;

   always_comb begin
      cmd_in.value = req_payload.value;
      unique case (req_payload.operation)
         OP_TICK:       cmd_in.kind = CMD_TICK;
         OP_SET_TARGET: cmd_in.kind = CMD_SET_TARGET;
         OP_ADD_TARGET: cmd_in.kind = CMD_ADD_TARGET;
         OP_ZERO:       cmd_in.kind = CMD_ZERO;
         OP_ADJUST:     cmd_in.kind = CMD_ADJUST;
         default:       cmd_in.kind = CMD_NOP;
      endcase
   end

   spc_fifo #(
      .WIDTH ($bits(cmd_type)),
      .DEPTH (CMD_DEPTH)
   ) u_cmd_fifo (
      .clock   (clock),
      .reset   (reset),
      .push    (push),
      .wr_data (cmd_in),
      .full    (full),
      .pop     (cmd_pop),
      .rd_data (cmd_bits),
      .empty   (cmd_empty)
   );

   assign cmd       = cmd_type'(cmd_bits);
   assign cmd_valid = !cmd_empty;

endmodule

// File: rtl/core/spc_back.sv
module spc_back import spc_pkg::*; #(
   parameter int POSITION_BITS = POSITION_BITS_DEFAULT
) (
   input  logic    clock,
   input  logic    reset,
   input  cfg_type cfg,
   input  cmd_type cmd,
   input  logic    cmd_valid,
   output logic    cmd_pop,
   output rsp_type rsp_payload,
   output logic    empty,
   input  logic    pop
);

   localparam int PB = POSITION_BITS;
   localparam int WB = 34;

   function automatic logic signed [PB-1:0] trim_pos(
      input logic signed [WB-1:0] p,
      input logic                 is_mod,
      input logic signed [WB-1:0] m
   );
      logic signed [WB-1:0] q;
      q = p;
      if (is_mod && q >= m) q = q - m;
      if (is_mod && q < 0) q = q + m;
      return q[PB-1:0];
   endfunction

   logic signed [PB-1:0] actual_ff, actual_in;
   logic signed [PB-1:0] target_ff, target_in;
   logic [2:0]           phase_ff, phase_in;
   logic [11:0]          backlash_ff, backlash_in;
   logic [32:0]          ticks_ff, ticks_in;
   logic [3:0]           coil_ff, coil_in;

   logic                 fire, rsp_full;
   logic                 is_mod, is_lim;
   logic signed [WB-1:0] mod_w, half_w, lower_w, upper_w;
   logic signed [PB-1:0] val_pb, tgt_src, target_set;
   logic signed [WB-1:0] tgt_w, clamp_lo, clamp_hi, clamp_w;
   logic [32:0]          ticks_inc;
   logic                 elapsed, powered_off;
   logic signed [PB-1:0] diff_pb;
   logic signed [WB-1:0] diff0, diff1, diff2;
   logic                 step_up, step_dn, count_up;
   logic [2:0]           phase_up, phase_dn;
   logic signed [PB-1:0] pos_up, pos_dn;
   rsp_type              rsp_in;
   logic [$bits(rsp_type)-1:0] rsp_bits;

   assign fire    = cmd_valid && !rsp_full;
   assign cmd_pop = fire;

   assign is_mod  = (cfg.axis_mode == AXIS_MODULO);
   assign is_lim  = (cfg.axis_mode == AXIS_LIMITED);
   assign mod_w   = WB'(cfg.modulo_steps);
   assign half_w  = WB'(cfg.modulo_steps[15:1]);
   assign lower_w = WB'(cfg.lower_limit);
   assign upper_w = WB'(cfg.upper_limit);
   assign val_pb  = cmd.value[PB-1:0];

   // new target: wrap, clamp on a limited axis, wrap, trim on a modulo axis
   assign tgt_src    = (cmd.kind == CMD_ADD_TARGET) ? target_ff + val_pb : val_pb;
   assign tgt_w      = WB'(tgt_src);
   assign clamp_lo   = (is_lim && tgt_w < lower_w) ? lower_w : tgt_w;
   assign clamp_hi   = (is_lim && clamp_lo > upper_w) ? upper_w : clamp_lo;
   assign clamp_w    = WB'(signed'(clamp_hi[PB-1:0]));
   assign target_set = trim_pos(clamp_w, is_mod, mod_w);

   // tick: step decision
   assign ticks_inc   = (ticks_ff == TICK_MAX) ? ticks_ff : ticks_ff + 33'd1;
   assign elapsed     = ticks_inc > 33'(cfg.step_delay);
   assign powered_off = (cfg.powersave_delay != '0) && (ticks_inc > 33'(cfg.powersave_delay));

   assign diff_pb = target_ff - actual_ff;
   assign diff0   = WB'(diff_pb);
   assign diff1   = (is_mod && diff0 > half_w) ? diff0 - mod_w : diff0;
   assign diff2   = (is_mod && diff1 < -half_w) ? diff1 + mod_w : diff1;
   assign step_up = elapsed && (diff2 > 0);
   assign step_dn = elapsed && (diff2 < 0);

   assign phase_up = phase_ff + 3'd1;
   assign phase_dn = phase_ff - 3'd1;
   assign count_up = ({1'b0, backlash_ff} + 13'd1) >= {1'b0, cfg.backlash_steps};
   assign pos_up   = trim_pos(WB'(actual_ff) + WB'(1), is_mod, mod_w);
   assign pos_dn   = trim_pos(WB'(actual_ff) - WB'(1), is_mod, mod_w);

   always_comb begin
      actual_in   = actual_ff;
      target_in   = target_ff;
      phase_in    = phase_ff;
      backlash_in = backlash_ff;
      ticks_in    = ticks_ff;
      coil_in     = coil_ff;
      if (fire) begin
         unique case (cmd.kind)
            CMD_TICK: begin
               ticks_in = ticks_inc;
               if (step_up) begin
                  phase_in = phase_up;
                  coil_in  = coil_of(phase_up ^ {3{cfg.reverse_dir}});
                  ticks_in = '0;
                  if (count_up) begin
                     actual_in = pos_up;
                  end else begin
                     backlash_in = backlash_ff + 12'd1;
                  end
               end else if (step_dn) begin
                  phase_in = phase_dn;
                  coil_in  = coil_of(phase_dn ^ {3{cfg.reverse_dir}});
                  ticks_in = '0;
                  if (backlash_ff != '0) begin
                     backlash_in = backlash_ff - 12'd1;
                  end else begin
                     actual_in = pos_dn;
                  end
               end else if (elapsed && powered_off) begin
                  coil_in = '0;
               end
            end
            CMD_SET_TARGET, CMD_ADD_TARGET: begin
               target_in = target_set;
            end
            CMD_ZERO: begin
               actual_in = '0;
               target_in = '0;
            end
            CMD_ADJUST: begin
               actual_in = actual_ff - val_pb;
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      rsp_in.coil_pattern = coil_in;
      rsp_in.position     = 32'(actual_in);
      rsp_in.target       = 32'(target_in);
      rsp_in.in_target    = (actual_in == target_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         actual_ff   <= '0;
         target_ff   <= '0;
         phase_ff    <= '0;
         backlash_ff <= '0;
         ticks_ff    <= '0;
         coil_ff     <= '0;
      end else begin
         actual_ff   <= actual_in;
         target_ff   <= target_in;
         phase_ff    <= phase_in;
         backlash_ff <= backlash_in;
         ticks_ff    <= ticks_in;
         coil_ff     <= coil_in;
      end
   end

   spc_fifo #(
      .WIDTH ($bits(rsp_type)),
      .DEPTH (RSP_DEPTH)
   ) u_rsp_fifo (
      .clock   (clock),
      .reset   (reset),
      .push    (fire),
      .wr_data (rsp_in),
      .full    (rsp_full),
      .pop     (pop),
      .rd_data (rsp_bits),
      .empty   (empty)
   );

   assign rsp_payload = rsp_type'(rsp_bits);

endmodule

// File: rtl/core/stepper_position_controller_unit.sv
// Half-step position controller for a four-coil unipolar stepper. Each request is a
// one-microsecond tick, an absolute or relative target, a zeroing of both positions or an
// adjust of the actual position, and each gives exactly one result with the coil pattern,
// position, target and an in-target flag after that request. Requests go into a command
// queue; unless the result queue is full, the execute stage takes one command per clock
// cycle and writes its result there, so one request per cycle is sustained. A result
// passes the command queue and the execute stage into the result queue. The execute
// stage updates position, backlash, phase and tick counter for each command, which sets
// that rate. Positions are POSITION_BITS wide (16 to 32) and sign-extended on the
// result. The user must write registers only while idle; the block does not enforce it.
module stepper_position_controller_unit import spc_pkg::*; #(
   parameter int POSITION_BITS = POSITION_BITS_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  req_type                   req_payload,
   output logic                      full,
   output logic                      empty,
   input  logic                      pop,
   output rsp_type                   rsp_payload,
   input  logic                      csr_wr_en,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_wdata
);

   cfg_type cfg_ff, cfg_in;
   cmd_type cmd;
   logic    cmd_valid, cmd_pop;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            REG_AXIS_MODE:       cfg_in.axis_mode       = csr_wdata[1:0];
            REG_MODULO_STEPS:    cfg_in.modulo_steps    = csr_wdata[15:0];
            REG_LOWER_LIMIT:     cfg_in.lower_limit     = csr_wdata[31:0];
            REG_UPPER_LIMIT:     cfg_in.upper_limit     = csr_wdata[31:0];
            REG_BACKLASH_STEPS:  cfg_in.backlash_steps  = csr_wdata[11:0];
            REG_STEP_DELAY:      cfg_in.step_delay      = csr_wdata[15:0];
            REG_POWERSAVE_DELAY: cfg_in.powersave_delay = csr_wdata[31:0];
            REG_REVERSE_DIR:     cfg_in.reverse_dir     = csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.axis_mode       <= AXIS_UNLIMITED;
         cfg_ff.modulo_steps    <= '0;
         cfg_ff.lower_limit     <= LOWER_LIMIT_RESET;
         cfg_ff.upper_limit     <= UPPER_LIMIT_RESET;
         cfg_ff.backlash_steps  <= '0;
         cfg_ff.step_delay      <= STEP_DELAY_RESET;
         cfg_ff.powersave_delay <= POWERSAVE_DELAY_RESET;
         cfg_ff.reverse_dir     <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   spc_front u_front (
      .clock       (clock),
      .reset       (reset),
      .push        (push),
      .req_payload (req_payload),
      .full        (full),
      .cmd         (cmd),
      .cmd_valid   (cmd_valid),
      .cmd_pop     (cmd_pop)
   );

   spc_back #(
      .POSITION_BITS (POSITION_BITS)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .cmd         (cmd),
      .cmd_valid   (cmd_valid),
      .cmd_pop     (cmd_pop),
      .rsp_payload (rsp_payload),
      .empty       (empty),
      .pop         (pop)
   );

endmodule

// File: sim/stepper_position_controller_unit_test.sv
`timescale 1ns / 1ps

module stepper_position_controller_unit_test;
   import spc_pkg::*;

   localparam logic [2:0]  OP_UNUSED_LO    = 3'd5;
   localparam logic [1:0]  AXIS_SPARE      = 2'd3;
   localparam longint      TICKS_SATURATED = 64'h1_ffff_ffff;
   // half-step coil levels, phase 0 in the low nibble
   localparam logic [31:0] HALF_STEP_COILS = 32'h198C_4623;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      push = 1'b0;
   req_type                   req_payload = '0;
   logic                      full;
   logic                      empty;
   logic                      pop = 1'b0;
   rsp_type                   rsp_payload;
   logic                      csr_wr_en = 1'b0;
   logic [CSR_INDEX_BITS-1:0] csr_index = REG_AXIS_MODE;
   logic [CSR_DATA_BITS-1:0]  csr_wdata = '0;

   cfg_type    shadow_cfg;
   longint     model_pos;
   longint     model_tgt;
   logic [2:0] model_phase;
   int         model_slack;
   longint     model_idle;
   logic [3:0] model_coils;

   rsp_type awaited_readouts[$];
   int      mismatches = 0;
   bit      sender_gaps = 1'b1;
   bit      reader_gaps = 1'b1;
   int      reader_hold = 0;

   always #5 clock = ~clock;

   stepper_position_controller_unit u_top (
      .clock       (clock),
      .reset       (reset),
      .push        (push),
      .req_payload (req_payload),
      .full        (full),
      .empty       (empty),
      .pop         (pop),
      .rsp_payload (rsp_payload),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   function automatic longint wrap_steps(input longint v);
      logic [31:0] low;
      low = v[31:0];
      return $signed(low);
   endfunction

   function automatic longint fold_modulo(input longint p);
      longint m;
      m = shadow_cfg.modulo_steps;
      if (shadow_cfg.axis_mode == AXIS_MODULO) begin
         if (p >= m) p -= m;
         if (p < 0) p += m;
      end
      return wrap_steps(p);
   endfunction

   function automatic void aim_at(input longint p);
      longint lo;
      longint hi;
      lo = $signed(shadow_cfg.lower_limit);
      hi = $signed(shadow_cfg.upper_limit);
      p = wrap_steps(p);
      if (shadow_cfg.axis_mode == AXIS_LIMITED) begin
         if (p < lo) p = lo;
         if (p > hi) p = hi;
         p = wrap_steps(p);
      end
      model_tgt = fold_modulo(p);
   endfunction

   function automatic void drive_phase(input logic [2:0] ph);
      logic [2:0] shown;
      model_phase = ph;
      shown = shadow_cfg.reverse_dir ? 3'd7 - ph : ph;
      model_coils = HALF_STEP_COILS[shown*4 +: 4];
   endfunction

   function automatic void take_tick();
      longint diff;
      longint m;
      longint half;
      longint step_gap;
      longint save_gap;
      int     lash;
      m = shadow_cfg.modulo_steps;
      half = m >> 1;
      step_gap = shadow_cfg.step_delay;
      save_gap = shadow_cfg.powersave_delay;
      lash = shadow_cfg.backlash_steps;
      if (model_idle < TICKS_SATURATED) model_idle++;
      if (model_idle > step_gap) begin
         diff = wrap_steps(model_tgt - model_pos);
         if (shadow_cfg.axis_mode == AXIS_MODULO) begin
            if (diff > half) diff -= m;
            if (diff < -half) diff += m;
         end
         if (diff > 0) begin
            drive_phase(model_phase + 3'd1);
            if (model_slack + 1 < lash) model_slack++;
            else model_pos = fold_modulo(model_pos + 1);
            model_idle = 0;
         end else if (diff < 0) begin
            drive_phase(model_phase - 3'd1);
            if (model_slack > 0) model_slack--;
            else model_pos = fold_modulo(model_pos - 1);
            model_idle = 0;
         end
         if (save_gap > 0 && model_idle > save_gap) model_coils = '0;
      end
   endfunction

   function automatic rsp_type readout_after(input req_type r);
      rsp_type res;
      longint  v;
      v = $signed(r.value);
      case (r.operation)
         OP_TICK: take_tick();
         OP_SET_TARGET: aim_at(v);
         OP_ADD_TARGET: aim_at(model_tgt + v);
         OP_ZERO: begin
            model_pos = 0;
            model_tgt = 0;
         end
         OP_ADJUST: model_pos = wrap_steps(model_pos - v);
         default: ;
      endcase
      res.coil_pattern = model_coils;
      res.position = model_pos[31:0];
      res.target = model_tgt[31:0];
      res.in_target = (model_pos == model_tgt);
      return res;
   endfunction

   function automatic req_type request_of(input logic [2:0] op, input logic signed [31:0] v);
      req_type r;
      r.operation = op;
      r.value = v;
      return r;
   endfunction

   function automatic req_type random_request(input int center, input int span);
      req_type r;
      int      pick;
      int      off;
      pick = $urandom_range(0, 99);
      off = $urandom_range(0, 2 * span);
      r.value = $urandom;
      if (pick < 70) begin
         r.operation = OP_TICK;
      end else if (pick < 80) begin
         r.operation = OP_SET_TARGET;
         r.value = center + off - span;
      end else if (pick < 87) begin
         r.operation = OP_ADD_TARGET;
         r.value = (off - span) / 2;
      end else if (pick < 90) begin
         r.operation = OP_ZERO;
      end else if (pick < 95) begin
         r.operation = OP_ADJUST;
         r.value = off % 11 - 5;
      end else if (pick < 97) begin
         r.operation = OP_UNUSED_LO + 3'($urandom_range(0, 2));
      end else begin
         case ($urandom_range(0, 2))
            0: r.operation = OP_SET_TARGET;
            1: r.operation = OP_ADD_TARGET;
            default: r.operation = OP_ADJUST;
         endcase
      end
      return r;
   endfunction

   task automatic send_request(input req_type r);
      int gap;
      gap = sender_gaps ? $urandom_range(0, 19) : 0;
      @(negedge clock);
      if (gap > 0) begin
         push <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      push <= 1'b1;
      req_payload <= r;
      @(posedge clock);
      while (full) @(posedge clock);
      awaited_readouts.push_back(readout_after(r));
   endtask

   task automatic send_op(input logic [2:0] op, input logic signed [31:0] v);
      send_request(request_of(op, v));
   endtask

   task automatic send_ticks(input int count);
      repeat (count) send_op(OP_TICK, $urandom);
   endtask

   task automatic settle();
      @(negedge clock);
      push <= 1'b0;
      while (awaited_readouts.size() != 0) @(posedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_BITS-1:0] index, input logic [31:0] data);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      case (index)
         REG_AXIS_MODE:       shadow_cfg.axis_mode = data[1:0];
         REG_MODULO_STEPS:    shadow_cfg.modulo_steps = data[15:0];
         REG_LOWER_LIMIT:     shadow_cfg.lower_limit = data;
         REG_UPPER_LIMIT:     shadow_cfg.upper_limit = data;
         REG_BACKLASH_STEPS:  shadow_cfg.backlash_steps = data[11:0];
         REG_STEP_DELAY:      shadow_cfg.step_delay = data[15:0];
         REG_POWERSAVE_DELAY: shadow_cfg.powersave_delay = data;
         default:             shadow_cfg.reverse_dir = data[0];
      endcase
   endtask

   task automatic run_mix(input int count, input int center, input int span);
      for (int i = 0; i < count; i++) begin
         if (i % 25 == 0) begin
            sender_gaps = ($urandom_range(0, 3) != 0);
            reader_gaps = ($urandom_range(0, 3) != 0);
         end
         send_request(random_request(center, span));
      end
   endtask

   task automatic test_reset_values();
      send_op(OP_TICK, 32'sd0);
      send_op(OP_TICK, -32'sd1);
      send_op(OP_SET_TARGET, 32'sh7fff_ffff);
      send_op(OP_ADD_TARGET, 32'sd1);
      send_op(OP_SET_TARGET, 32'sh8000_0000);
      send_op(OP_ADD_TARGET, -32'sd1);
      send_op(OP_ZERO, -32'sd1);
      send_op(OP_ADJUST, 32'sh8000_0000);
      send_op(OP_ADJUST, -32'sd1);
      send_op(OP_ADJUST, 32'sh7fff_ffff);
      send_op(OP_ZERO, 32'sd0);
      for (int k = 0; k < 3; k++) send_op(OP_UNUSED_LO + 3'(k), -32'sd1);
      send_op(OP_TICK, 32'sd0);
   endtask

   task automatic test_step_timing();
      settle();
      write_reg(REG_STEP_DELAY, 32'd3);
      write_reg(REG_POWERSAVE_DELAY, 32'd0);
      send_op(OP_ZERO, 32'sd0);
      send_op(OP_SET_TARGET, 32'sd2);
      send_ticks(10);
      settle();
      write_reg(REG_STEP_DELAY, 32'd0);
      write_reg(REG_POWERSAVE_DELAY, 32'd2);
      send_op(OP_SET_TARGET, 32'sd3);
      send_ticks(8);
      settle();
      write_reg(REG_POWERSAVE_DELAY, 32'd0);
      run_mix(150, 0, 20);
   endtask

   task automatic test_backlash();
      settle();
      write_reg(REG_BACKLASH_STEPS, 32'd3);
      write_reg(REG_STEP_DELAY, 32'd2);
      write_reg(REG_POWERSAVE_DELAY, 32'd5);
      write_reg(REG_REVERSE_DIR, 32'd1);
      send_op(OP_ZERO, 32'sd0);
      send_op(OP_SET_TARGET, 32'sd4);
      send_ticks(12);
      send_op(OP_SET_TARGET, -32'sd2);
      send_ticks(12);
      run_mix(150, 0, 15);
   endtask

   task automatic test_modulo_axis();
      settle();
      write_reg(REG_AXIS_MODE, 32'(AXIS_MODULO));
      write_reg(REG_MODULO_STEPS, 32'd200);
      write_reg(REG_BACKLASH_STEPS, 32'd1);
      write_reg(REG_STEP_DELAY, 32'd1);
      write_reg(REG_POWERSAVE_DELAY, 32'd3);
      send_op(OP_ZERO, 32'sd0);
      send_op(OP_SET_TARGET, 32'sd195);
      send_ticks(6);
      send_op(OP_SET_TARGET, 32'sd230);
      send_op(OP_SET_TARGET, -32'sd30);
      run_mix(150, 100, 180);
      settle();
      write_reg(REG_MODULO_STEPS, 32'd65535);
      write_reg(REG_BACKLASH_STEPS, 32'd0);
      write_reg(REG_STEP_DELAY, 32'd0);
      send_op(OP_ZERO, 32'sd0);
      send_op(OP_SET_TARGET, 32'sd65533);
      send_ticks(5);
      send_op(OP_SET_TARGET, -32'sd3);
      run_mix(50, 0, 40);
      settle();
      write_reg(REG_MODULO_STEPS, 32'd0);
      run_mix(30, 0, 10);
   endtask

   task automatic test_limited_axis();
      settle();
      write_reg(REG_AXIS_MODE, 32'(AXIS_LIMITED));
      write_reg(REG_LOWER_LIMIT, -32'sd20);
      write_reg(REG_UPPER_LIMIT, 32'sd25);
      write_reg(REG_BACKLASH_STEPS, 32'd2);
      write_reg(REG_REVERSE_DIR, 32'd0);
      send_op(OP_SET_TARGET, 32'sh7fff_ffff);
      send_op(OP_SET_TARGET, 32'sh8000_0000);
      send_op(OP_ADD_TARGET, 32'sd100);
      run_mix(120, 0, 40);
      settle();
      // lower above upper: upper wins
      write_reg(REG_LOWER_LIMIT, 32'sd10);
      write_reg(REG_UPPER_LIMIT, -32'sd10);
      write_reg(REG_BACKLASH_STEPS, 32'd4095);
      run_mix(40, 0, 30);
      settle();
      write_reg(REG_LOWER_LIMIT, 32'sh8000_0000);
      write_reg(REG_UPPER_LIMIT, 32'sh7fff_ffff);
      write_reg(REG_BACKLASH_STEPS, 32'd0);
      send_op(OP_SET_TARGET, 32'sh8000_0000);
      send_op(OP_SET_TARGET, 32'sh7fff_ffff);
      run_mix(40, 0, 20);
   endtask

   task automatic test_spare_mode_extremes();
      settle();
      write_reg(REG_AXIS_MODE, 32'(AXIS_SPARE));
      write_reg(REG_STEP_DELAY, 32'd65535);
      write_reg(REG_POWERSAVE_DELAY, 32'hffff_ffff);
      write_reg(REG_REVERSE_DIR, 32'd1);
      run_mix(30, 0, 20);
   endtask

   task automatic test_backpressure();
      settle();
      write_reg(REG_AXIS_MODE, 32'(AXIS_UNLIMITED));
      write_reg(REG_STEP_DELAY, 32'd0);
      write_reg(REG_POWERSAVE_DELAY, 32'd4);
      sender_gaps = 1'b0;
      reader_gaps = 1'b0;
      reader_hold = 100;
      for (int i = 0; i < 60; i++) send_request(random_request(0, 10));
      sender_gaps = 1'b1;
      reader_gaps = 1'b1;
   endtask

   task automatic test_random_settings();
      for (int round = 0; round < 4; round++) begin
         settle();
         write_reg(REG_AXIS_MODE, $urandom_range(0, 3));
         write_reg(REG_MODULO_STEPS, $urandom_range(1, 300));
         write_reg(REG_LOWER_LIMIT, -$urandom_range(0, 50));
         write_reg(REG_UPPER_LIMIT, $urandom_range(0, 50) - 10);
         write_reg(REG_BACKLASH_STEPS, $urandom_range(0, 5));
         write_reg(REG_STEP_DELAY, $urandom_range(0, 3));
         write_reg(REG_POWERSAVE_DELAY, $urandom_range(0, 10));
         write_reg(REG_REVERSE_DIR, $urandom_range(0, 1));
         run_mix(25, 0, 40);
      end
   endtask

   initial begin : result_reader
      int stall;
      wait (reset == 1'b0);
      @(negedge clock);
      forever begin
         if (reader_hold > 0) begin
            pop <= 1'b0;
            repeat (reader_hold) @(negedge clock);
            reader_hold = 0;
         end
         stall = reader_gaps ? $urandom_range(0, 19) : 0;
         if (stall > 0) begin
            pop <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         pop <= 1'b1;
         @(posedge clock);
         while (empty) @(posedge clock);
         @(negedge clock);
      end
   end

   always @(posedge clock) begin : result_check
      rsp_type want;
      if (!reset && pop && !empty) begin
         if (awaited_readouts.size() == 0) begin
            $error("result with no request outstanding: %h", rsp_payload);
            mismatches++;
         end else begin
            want = awaited_readouts.pop_front();
            if (rsp_payload.coil_pattern !== want.coil_pattern) begin
               $error("coil_pattern: expected %h, actual %h",
                      want.coil_pattern, rsp_payload.coil_pattern);
               mismatches++;
            end
            if (rsp_payload.position !== want.position) begin
               $error("position: expected %0d, actual %0d", want.position, rsp_payload.position);
               mismatches++;
            end
            if (rsp_payload.target !== want.target) begin
               $error("target: expected %0d, actual %0d", want.target, rsp_payload.target);
               mismatches++;
            end
            if (rsp_payload.in_target !== want.in_target) begin
               $error("in_target: expected %b, actual %b", want.in_target, rsp_payload.in_target);
               mismatches++;
            end
         end
      end
   end

   initial begin
      #5_000_000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin
      shadow_cfg.axis_mode = AXIS_UNLIMITED;
      shadow_cfg.modulo_steps = '0;
      shadow_cfg.lower_limit = LOWER_LIMIT_RESET;
      shadow_cfg.upper_limit = UPPER_LIMIT_RESET;
      shadow_cfg.backlash_steps = '0;
      shadow_cfg.step_delay = STEP_DELAY_RESET;
      shadow_cfg.powersave_delay = POWERSAVE_DELAY_RESET;
      shadow_cfg.reverse_dir = 1'b0;
      model_pos = 0;
      model_tgt = 0;
      model_phase = '0;
      model_slack = 0;
      model_idle = 0;
      model_coils = '0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_reset_values();
      test_step_timing();
      test_backlash();
      test_modulo_axis();
      test_limited_axis();
      test_spare_mode_extremes();
      test_backpressure();
      test_random_settings();
      settle();
      repeat (10) @(posedge clock);
      if (mismatches == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
